// ===== hw/rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared width, counter width and sequencer state codes for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH:0]   wide_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_TEST = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/mexp_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_alu
// Shared modular add unit: two add-and-fold lanes, each returning its sum
// reduced below the modulus with a single compare and subtract.
// ----------------------------------------------------------------------------
module mexp_alu (
  input  mexp_pkg::wide_t mz,
  input  mexp_pkg::word_t x0,
  input  mexp_pkg::word_t y0,
  input  mexp_pkg::word_t x1,
  input  mexp_pkg::word_t y1,
  input  logic            cin1,
  output mexp_pkg::word_t z0,
  output mexp_pkg::word_t z1
);

  mexp_pkg::wide_t s0;
  mexp_pkg::wide_t s1;
  mexp_pkg::wide_t d0;
  mexp_pkg::wide_t d1;

  assign s0 = {1'b0, x0} + {1'b0, y0};
  assign s1 = {1'b0, x1} + {1'b0, y1} + {{mexp_pkg::WIDTH{1'b0}}, cin1};
  assign d0 = s0 - mz;
  assign d1 = s1 - mz;

  assign z0 = (s0 >= mz) ? d0[mexp_pkg::WIDTH-1:0] : s0[mexp_pkg::WIDTH-1:0];
  assign z1 = (s1 >= mz) ? d1[mexp_pkg::WIDTH-1:0] : s1[mexp_pkg::WIDTH-1:0];

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply power modulo a configured modulus, every
// product formed by shift-and-add on one shared modular add unit.
// ----------------------------------------------------------------------------
// sequence: the base is first reduced bit by bit, then per exponent bit one
//   test, a multiply when the bit is set and a square, with no square after
//   the top set bit
// throughput: one beat at a time, the next accepted after the result is taken
// reset: synchronous, returns to idle and sets the modulus to 1
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] base,
  input  logic [63:0] exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] power
);

  localparam int W = mexp_pkg::WIDTH;

  mexp_pkg::state_t state, state_next;
  logic [mexp_pkg::CNT_W-1:0] cnt, cnt_next;
  mexp_pkg::word_t modulus;
  mexp_pkg::word_t e, e_next;
  mexp_pkg::word_t acc, acc_next;
  mexp_pkg::word_t sq, sq_next;
  mexp_pkg::word_t mul_a, mul_a_next;
  mexp_pkg::word_t mul_b, mul_b_next;
  mexp_pkg::word_t prod, prod_next;

  mexp_pkg::wide_t mz;
  mexp_pkg::word_t y0;
  mexp_pkg::word_t z0;
  mexp_pkg::word_t z1;
  logic            cin1;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mexp_pkg::S_IDLE);
  assign out_valid = (state == mexp_pkg::S_OUT);
  assign power     = 64'(acc);

  // zero modulus acts as 2^WIDTH
  assign mz   = {~|modulus, modulus};
  assign y0   = mul_a[0] ? mul_b : '0;
  assign cin1 = (state == mexp_pkg::S_RED) ? mul_a[W-1] : 1'b0;

  mexp_alu u_alu (
    .mz   (mz),
    .x0   (prod),
    .y0   (y0),
    .x1   (mul_b),
    .y1   (mul_b),
    .cin1 (cin1),
    .z0   (z0),
    .z1   (z1)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    e_next     = e;
    acc_next   = acc;
    sq_next    = sq;
    mul_a_next = mul_a;
    mul_b_next = mul_b;
    prod_next  = prod;
    case (state)
      mexp_pkg::S_IDLE: begin
        if (in_valid) begin
          mul_a_next = base[W-1:0];
          mul_b_next = '0;
          e_next     = exponent[W-1:0];
          acc_next   = W'(1);
          cnt_next   = mexp_pkg::CNT_W'(W - 1);
          state_next = mexp_pkg::S_RED;
        end
      end
      mexp_pkg::S_RED: begin
        // restoring remainder, one base bit per cycle
        mul_b_next = z1;
        mul_a_next = {mul_a[W-2:0], 1'b0};
        cnt_next   = cnt - 1'b1;
        if (cnt == '0) begin
          sq_next    = z1;
          state_next = mexp_pkg::S_TEST;
        end
      end
      mexp_pkg::S_TEST: begin
        if (e[0]) begin
          mul_a_next = acc;
          mul_b_next = sq;
          prod_next  = '0;
          state_next = mexp_pkg::S_MUL;
        end else begin
          e_next = {1'b0, e[W-1:1]};
          if (e[W-1:1] == '0) begin
            state_next = mexp_pkg::S_OUT;
          end else begin
            mul_a_next = sq;
            mul_b_next = sq;
            prod_next  = '0;
            state_next = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_MUL: begin
        prod_next  = z0;
        mul_b_next = z1;
        mul_a_next = {1'b0, mul_a[W-1:1]};
        if (mul_a[W-1:1] == '0) begin
          acc_next = z0;
          e_next   = {1'b0, e[W-1:1]};
          if (e[W-1:1] == '0) begin
            state_next = mexp_pkg::S_OUT;
          end else begin
            mul_a_next = sq;
            mul_b_next = sq;
            prod_next  = '0;
            state_next = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_SQR: begin
        prod_next  = z0;
        mul_b_next = z1;
        mul_a_next = {1'b0, mul_a[W-1:1]};
        if (mul_a[W-1:1] == '0) begin
          sq_next    = z0;
          state_next = mexp_pkg::S_TEST;
        end
      end
      mexp_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mexp_pkg::S_IDLE;
      modulus <= W'(1);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt   <= cnt_next;
    e     <= e_next;
    acc   <= acc_next;
    sq    <= sq_next;
    mul_a <= mul_a_next;
    mul_b <= mul_b_next;
    prod  <= prod_next;
  end

endmodule
